### src/swt_pkg.sv
package swt_pkg;
    localparam int NumProc = 16;
    localparam int PidW = $clog2(NumProc);
    localparam int DescW = $clog2(NumProc);
    localparam int KeyBits = 32;
    localparam int KeyInW = 32;

    typedef logic [1:0] t_req;
    typedef logic [1:0] t_status;

    localparam t_req REQ_BLOCK = 2'd0;
    localparam t_req REQ_UNBLOCK = 2'd1;
    localparam t_req REQ_REMOVE = 2'd2;
    localparam t_req REQ_PEEK = 2'd3;

    localparam t_status ST_OK = 2'd0;
    localparam t_status ST_FULL = 2'd1;
    localparam t_status ST_NONE = 2'd2;
    localparam t_status ST_DUP = 2'd3;
endpackage

### src/semaphore_wait_table_top.sv
// Sequential semaphore wait table: one request at a time, o_stall high while busy.
// Block, unblock and peek search all NumProc descriptors, one compared per cycle, then
// act; a remove walks its queue one link per cycle; a repeated block or a remove of
// an idle process goes straight to the result. A new request is accepted only after
// the result is taken; output stalls hold the result.
// Reset (synchronous, active low) clears control, used and blocked bits only.
module semaphore_wait_table_top (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  swt_pkg::t_req              i_req_type,
    input  logic [swt_pkg::KeyInW-1:0] i_sem_key,
    input  logic [swt_pkg::PidW-1:0]   i_proc_id,
    output logic                       o_valid,
    input  logic                       i_stall,
    output swt_pkg::t_status           o_status,
    output logic [swt_pkg::PidW-1:0]   o_out_proc
);
    import swt_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SRCH = 3'd1;
    localparam logic [2:0] S_ACT  = 3'd2;
    localparam logic [2:0] S_WALK = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    // tables
    logic [KeyBits-1:0] r_key [NumProc];
    logic [NumProc-1:0] r_used;
    logic [PidW-1:0]    r_head [NumProc];
    logic [PidW-1:0]    r_tail [NumProc];
    logic [PidW-1:0]    r_link [NumProc];
    logic [NumProc-1:0] r_blk;
    logic [DescW-1:0]   r_pdesc [NumProc];

    logic [2:0]         r_state;
    t_req               r_req;
    logic [KeyBits-1:0] r_k;
    logic [PidW-1:0]    r_p;
    logic [DescW:0]     r_idx;     // search / walk counter
    logic               r_hit;
    logic [DescW-1:0]   r_d;
    logic               r_free_ok;
    logic [DescW-1:0]   r_free;
    logic [PidW-1:0]    r_cur;
    logic [PidW-1:0]    r_prev;
    logic               r_has_prev;
    logic               r_ovalid;
    t_status            r_st;
    logic [PidW-1:0]    r_op;

    logic [DescW-1:0] w_i;
    assign w_i = r_idx[DescW-1:0];

    assign o_stall    = (r_state != S_IDLE);
    assign o_valid    = r_ovalid;
    assign o_status   = r_st;
    assign o_out_proc = r_op;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_used   <= '0;
            r_blk    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_req      <= i_req_type;
                        r_k        <= i_sem_key[KeyBits-1:0];
                        r_p        <= i_proc_id;
                        r_idx      <= '0;
                        r_hit      <= 1'b0;
                        r_free_ok  <= 1'b0;
                        r_has_prev <= 1'b0;
                        if (i_req_type == REQ_BLOCK && r_blk[i_proc_id]) begin
                            r_st    <= ST_DUP;
                            r_op    <= '0;
                            r_state <= S_DONE;
                        end else if (i_req_type == REQ_REMOVE) begin
                            if (!r_blk[i_proc_id] || !r_used[r_pdesc[i_proc_id]]) begin
                                r_st    <= ST_NONE;
                                r_op    <= '0;
                                r_state <= S_DONE;
                            end else begin
                                r_d     <= r_pdesc[i_proc_id];
                                r_cur   <= r_head[r_pdesc[i_proc_id]];
                                r_state <= S_WALK;
                            end
                        end else begin
                            r_state <= S_SRCH;
                        end
                    end
                end
                // one descriptor compared per cycle
                S_SRCH: begin
                    if (!r_hit && r_used[w_i] && r_key[w_i] == r_k) begin
                        r_hit <= 1'b1;
                        r_d   <= w_i;
                    end
                    if (!r_free_ok && !r_used[w_i]) begin
                        r_free_ok <= 1'b1;
                        r_free    <= w_i;
                    end
                    r_idx <= r_idx + (DescW+1)'(1);
                    if (r_idx == (DescW+1)'(NumProc-1)) r_state <= S_ACT;
                end
                S_ACT: begin
                    r_state <= S_DONE;
                    case (r_req)
                        REQ_BLOCK: begin
                            if (r_hit) begin
                                r_link[r_tail[r_d]] <= r_p;
                                r_tail[r_d]         <= r_p;
                                r_pdesc[r_p]        <= r_d;
                                r_blk[r_p]          <= 1'b1;
                                r_st                <= ST_OK;
                                r_op                <= r_p;
                            end else if (r_free_ok) begin
                                r_used[r_free] <= 1'b1;
                                r_key[r_free]  <= r_k;
                                r_head[r_free] <= r_p;
                                r_tail[r_free] <= r_p;
                                r_pdesc[r_p]   <= r_free;
                                r_blk[r_p]     <= 1'b1;
                                r_st           <= ST_OK;
                                r_op           <= r_p;
                            end else begin
                                r_st <= ST_FULL;
                                r_op <= '0;
                            end
                        end
                        REQ_UNBLOCK: begin
                            if (!r_hit) begin
                                r_st <= ST_NONE;
                                r_op <= '0;
                            end else begin
                                if (r_head[r_d] == r_tail[r_d]) r_used[r_d] <= 1'b0;
                                else r_head[r_d] <= r_link[r_head[r_d]];
                                r_blk[r_head[r_d]] <= 1'b0;
                                r_st <= ST_OK;
                                r_op <= r_head[r_d];
                            end
                        end
                        default: begin
                            if (!r_hit) begin
                                r_st <= ST_NONE;
                                r_op <= '0;
                            end else begin
                                r_st <= ST_OK;
                                r_op <= r_head[r_d];
                            end
                        end
                    endcase
                end
                // remove: one link per cycle
                S_WALK: begin
                    if (r_cur == r_p) begin
                        if (!r_has_prev) begin
                            if (r_p == r_tail[r_d]) r_used[r_d] <= 1'b0;
                            else r_head[r_d] <= r_link[r_p];
                        end else begin
                            r_link[r_prev] <= r_link[r_p];
                            if (r_p == r_tail[r_d]) r_tail[r_d] <= r_prev;
                        end
                        r_blk[r_p] <= 1'b0;
                        r_state    <= S_DONE;
                        r_st       <= ST_OK;
                        r_op       <= r_p;
                    end else if (r_cur == r_tail[r_d] ||
                                 r_idx == (DescW+1)'(NumProc-1)) begin
                        r_state <= S_DONE;
                        r_st    <= ST_NONE;
                        r_op    <= '0;
                    end else begin
                        r_prev     <= r_cur;
                        r_has_prev <= 1'b1;
                        r_cur      <= r_link[r_cur];
                        r_idx      <= r_idx + (DescW+1)'(1);
                    end
                end
                // hold the result until taken
                S_DONE: begin
                    if (!r_ovalid) begin
                        r_ovalid <= 1'b1;
                    end else if (!i_stall) begin
                        r_ovalid <= 1'b0;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

### dv/semaphore_wait_table_top_tb.sv
module semaphore_wait_table_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import swt_pkg::*;

    localparam int WatchdogLimit = 20000;

    logic          clk;
    logic          rst_n;
    logic          in_valid;
    logic          in_stall;
    t_req          in_req;
    logic [31:0]   in_key;
    logic [3:0]    in_pid;
    logic          out_valid;
    logic          out_stall;
    t_status       out_status;
    logic [3:0]    out_pid;

    semaphore_wait_table_top i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_valid    (in_valid),
        .o_stall    (in_stall),
        .i_req_type (in_req),
        .i_sem_key  (in_key),
        .i_proc_id  (in_pid),
        .o_valid    (out_valid),
        .i_stall    (out_stall),
        .o_status   (out_status),
        .o_out_proc (out_pid)
    );

    // Clock
    always begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Predictor copy of the table
    logic [31:0] sem_key_tab [NumProc];
    logic        sem_used    [NumProc];
    logic [3:0]  sem_head    [NumProc];
    logic [3:0]  sem_tail    [NumProc];
    logic [3:0]  pid_next    [NumProc];
    logic        pid_waiting [NumProc];
    logic [3:0]  pid_sem     [NumProc];

    typedef struct packed {
        t_status    status;
        logic [3:0] pid;
    } t_outcome;

    t_outcome    pending_q[$];
    int          mismatches;
    bit          stim_done;
    int          idle_cycles;
    bit          long_hold;

    function automatic int find_sem(logic [31:0] key);
        for (int d = 0; d < NumProc; d++)
            if (sem_used[d] && sem_key_tab[d] == key) return d;
        return NumProc;
    endfunction

    // Applies one request to the table copy and returns its outcome
    function automatic t_outcome apply_request(t_req req, logic [31:0] key,
                                               logic [3:0] p);
        t_outcome r;
        int d;
        int cur;
        int prev;
        bit found;
        r = '{status: ST_NONE, pid: 4'd0};
        case (req)
            REQ_BLOCK: begin
                if (pid_waiting[p]) begin
                    r.status = ST_DUP;
                    return r;
                end
                d = find_sem(key);
                if (d < NumProc) begin
                    pid_next[sem_tail[d]] = p;
                    sem_tail[d] = p;
                end else begin
                    for (d = 0; d < NumProc; d++)
                        if (!sem_used[d]) break;
                    if (d >= NumProc) begin
                        r.status = ST_FULL;
                        return r;
                    end
                    sem_used[d] = 1'b1;
                    sem_key_tab[d] = key;
                    sem_head[d] = p;
                    sem_tail[d] = p;
                end
                pid_next[p] = 4'd0;
                pid_waiting[p] = 1'b1;
                pid_sem[p] = d[3:0];
                r = '{status: ST_OK, pid: p};
            end
            REQ_UNBLOCK: begin
                d = find_sem(key);
                if (d >= NumProc) return r;
                cur = sem_head[d];
                if (cur == sem_tail[d]) sem_used[d] = 1'b0;
                else sem_head[d] = pid_next[cur];
                pid_waiting[cur] = 1'b0;
                r = '{status: ST_OK, pid: cur[3:0]};
            end
            REQ_REMOVE: begin
                if (!pid_waiting[p]) return r;
                d = pid_sem[p];
                if (!sem_used[d]) return r;
                cur = sem_head[d];
                prev = NumProc;
                found = 1'b0;
                for (int i = 0; i < NumProc; i++) begin
                    if (cur == p) begin
                        found = 1'b1;
                        break;
                    end
                    if (cur == sem_tail[d]) break;
                    prev = cur;
                    cur = pid_next[cur];
                end
                if (!found) return r;
                if (prev >= NumProc) begin
                    if (p == sem_tail[d]) sem_used[d] = 1'b0;
                    else sem_head[d] = pid_next[p];
                end else begin
                    pid_next[prev] = pid_next[p];
                    if (p == sem_tail[d]) sem_tail[d] = prev[3:0];
                end
                pid_waiting[p] = 1'b0;
                r = '{status: ST_OK, pid: p};
            end
            default: begin
                d = find_sem(key);
                if (d >= NumProc) return r;
                r = '{status: ST_OK, pid: sem_head[d]};
            end
        endcase
        return r;
    endfunction

    // Directed table; hard_chk marks rows whose outcome is typed in
    typedef struct {
        t_req        req;
        logic [31:0] key;
        logic [3:0]  pid;
        bit          hard_chk;
        t_outcome    outcome;
    } t_row;

    t_row directed[$];

    function automatic void add_row(t_req req, logic [31:0] key, logic [3:0] p,
                                    bit hc, t_status st, logic [3:0] op);
        t_row row;
        row.req = req;
        row.key = key;
        row.pid = p;
        row.hard_chk = hc;
        row.outcome = '{status: st, pid: op};
        directed.push_back(row);
    endfunction

    // Send one item: predict at acceptance
    task automatic send_item(t_req req, logic [31:0] key, logic [3:0] p,
                             bit hc, t_outcome typed);
        t_outcome pred;
        in_valid <= 1'b1;
        in_req   <= req;
        in_key   <= key;
        in_pid   <= p;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        pred = apply_request(req, key, p);
        if (hc && pred != typed) begin
            mismatches++;
            if (mismatches <= 10)
                $display("directed row typed %0d/%0d but predictor %0d/%0d",
                         typed.status, typed.pid, pred.status, pred.pid);
        end
        pending_q.push_back(hc ? typed : pred);
    endtask

    // Idle gap between bursts
    task automatic gap(int n);
        if (n > 0) begin
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    logic [31:0] key_pool[6];

    function automatic logic [31:0] pick_key();
        if ($urandom_range(0, 9) == 0) return $urandom();
        return key_pool[$urandom_range(0, 5)];
    endfunction

    // Stimulus
    initial begin
        int burst;
        t_req rq;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_req    = REQ_BLOCK;
        in_key    = '0;
        in_pid    = '0;
        mismatches = 0;
        stim_done = 1'b0;
        long_hold = 1'b0;
        for (int i = 0; i < NumProc; i++) begin
            sem_used[i] = 1'b0;
            pid_waiting[i] = 1'b0;
        end
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty table, extreme keys, duplicates, every process blocked, removals
        add_row(REQ_PEEK,    32'h0,        4'd0,  1, ST_NONE, 4'd0);
        add_row(REQ_UNBLOCK, 32'hFFFFFFFF, 4'd0,  1, ST_NONE, 4'd0);
        add_row(REQ_REMOVE,  32'h0,        4'd15, 1, ST_NONE, 4'd0);
        add_row(REQ_BLOCK,   32'hFFFFFFFF, 4'd15, 1, ST_OK,   4'd15);
        add_row(REQ_BLOCK,   32'hFFFFFFFF, 4'd15, 1, ST_DUP,  4'd0);
        add_row(REQ_BLOCK,   32'hFFFFFFFF, 4'd0,  1, ST_OK,   4'd0);
        add_row(REQ_BLOCK,   32'hFFFFFFFF, 4'd7,  1, ST_OK,   4'd7);
        add_row(REQ_PEEK,    32'hFFFFFFFF, 4'd3,  1, ST_OK,   4'd15);
        add_row(REQ_REMOVE,  32'h12345678, 4'd0,  0, ST_OK,   4'd0);
        add_row(REQ_REMOVE,  32'h0,        4'd7,  0, ST_OK,   4'd0);
        add_row(REQ_UNBLOCK, 32'hFFFFFFFF, 4'd9,  1, ST_OK,   4'd15);
        add_row(REQ_PEEK,    32'hFFFFFFFF, 4'd0,  1, ST_NONE, 4'd0);
        for (int i = 0; i < NumProc; i++)
            add_row(REQ_BLOCK, 32'h100 + i, i[3:0], 0, ST_OK, 4'd0);
        // 16 descriptors now in use; a blocked process on a new key is a duplicate
        add_row(REQ_BLOCK,   32'h0, 4'd3, 1, ST_DUP, 4'd0);
        foreach (directed[i])
            send_item(directed[i].req, directed[i].key, directed[i].pid,
                      directed[i].hard_chk, directed[i].outcome);
        // Free one process and its descriptor, then reuse it for a fresh key
        send_item(REQ_UNBLOCK, 32'h105, 4'd0, 0, '0);
        send_item(REQ_BLOCK, 32'hAAAA5555, 4'd5, 1, '{status: ST_OK, pid: 4'd5});
        gap(2);

        for (int i = 0; i < 6; i++) key_pool[i] = (i < 2) ? 32'h100 + i : $urandom();
        key_pool[5] = 32'h0;

        // Random part: mostly blocks and unblocks on a small key pool
        for (int n = 0; n < 1200; ) begin
            burst = $urandom_range(1, 30);
            if (n > 400 && n < 700) burst = 40;
            for (int b = 0; b < burst; b++) begin
                rq = t_req'($urandom_range(0, 99) < 40 ? REQ_BLOCK :
                            $urandom_range(0, 2) + 1);
                send_item(rq, pick_key(), 4'($urandom_range(0, 15)), 0, '0);
                n++;
            end
            gap($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12));
        end
        in_valid <= 1'b0;
        stim_done = 1'b1;
    end

    // Receiver stall pattern with one long hold-off
    initial begin
        int rx_cycles;
        rx_cycles = 0;
        out_stall = 1'b1;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            rx_cycles++;
            if (!long_hold && rx_cycles == 3000) begin
                long_hold = 1'b1;
                out_stall <= 1'b1;
                repeat (400) @(posedge clk);
            end
            case ($urandom_range(0, 3))
                0:       out_stall <= 1'b1;
                1:       out_stall <= ($urandom_range(0, 1) == 1);
                default: out_stall <= 1'b0;
            endcase
        end
    end

    // Result checker and watchdog
    always @(posedge clk) begin
        if (!rst_n) begin
            idle_cycles <= 0;
        end else begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (out_valid && !out_stall) begin
                if (pending_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected item status=%0d proc=%0d", out_status, out_pid);
                end else begin
                    t_outcome exp_o;
                    exp_o = pending_q.pop_front();
                    if (exp_o.status !== out_status || exp_o.pid !== out_pid) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("item mismatch: exp status=%0d proc=%0d got %0d/%0d",
                                     exp_o.status, exp_o.pid, out_status, out_pid);
                    end
                end
            end
        end
    end

    // End of run
    initial begin
        @(posedge rst_n);
        while (!(stim_done && pending_q.size() == 0) && idle_cycles < WatchdogLimit)
            @(posedge clk);
        if (idle_cycles >= WatchdogLimit) begin
            $display("CHECK FAILED");
        end else begin
            repeat (100) @(posedge clk);
            if (mismatches == 0 && pending_q.size() == 0) $display("CHECK OK");
            else $display("CHECK FAILED");
        end
        $finish;
    end
endmodule

### semaphore_wait_table_top.f
src/swt_pkg.sv
src/semaphore_wait_table_top.sv
dv/semaphore_wait_table_top_tb.sv
